[rtl/core/tdfs_pkg.sv]
// shared types and constants for the three-wire display frame sender
package tdfs_pkg;

  // fixed width of the message field
  localparam int unsigned MSG_W = 56;
  localparam int unsigned TICK_W = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP_TICKS        = 2'd0;
  localparam logic [1:0] CFG_LEAD_TICKS       = 2'd1;
  localparam logic [1:0] CFG_CLOCK_HIGH_TICKS = 2'd2;
  localparam logic [1:0] CFG_CLOCK_LOW_TICKS  = 2'd3;

  // configuration reset values
  localparam logic [TICK_W-1:0] GAP_TICKS_RST        = 8'd230;
  localparam logic [TICK_W-1:0] LEAD_TICKS_RST       = 8'd138;
  localparam logic [TICK_W-1:0] CLOCK_HIGH_TICKS_RST = 8'd150;
  localparam logic [TICK_W-1:0] CLOCK_LOW_TICKS_RST  = 8'd92;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // frame phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ENA_R1 = 4'd1,
    PH_ENA_F1 = 4'd2,
    PH_ENA_R2 = 4'd3,
    PH_CLK_F  = 4'd4,
    PH_CLK_R  = 4'd5,
    PH_ENA_F2 = 4'd6,
    PH_ENA_R3 = 4'd7,
    PH_ENA_F3 = 4'd8,
    PH_POST   = 4'd9
  } phase_t;

  typedef struct packed {
    logic             opcode;
    logic [MSG_W-1:0] message;
  } in_word_t;

  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic enable_pin;
    logic clock_pin;
    logic data_pin;
  } out_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] gap_ticks;
    logic [TICK_W-1:0] lead_ticks;
    logic [TICK_W-1:0] clock_high_ticks;
    logic [TICK_W-1:0] clock_low_ticks;
  } cfg_t;

  // frame state apart from the bit counter
  typedef struct packed {
    phase_t            phase;
    logic [TICK_W-1:0] wait_count;
    logic              second_pass;
    logic [MSG_W-1:0]  message_store;
    logic              en;
    logic              clk;
    logic              dat;
  } state_t;

endpackage

[rtl/core/tdfs_step.sv]
// next-state and result logic for one word of the frame sender
module tdfs_step #(
  parameter int unsigned MSG_BITS = 56,
  parameter int unsigned BIT_W    = 6
) (
  input  tdfs_pkg::state_t    cur,
  input  logic [BIT_W-1:0]    cur_bit_index,
  input  tdfs_pkg::cfg_t      cfg,
  input  tdfs_pkg::in_word_t  in_word,
  output tdfs_pkg::state_t    nxt,
  output logic [BIT_W-1:0]    nxt_bit_index,
  output tdfs_pkg::out_word_t out_word
);
  import tdfs_pkg::*;

  logic [MSG_W-1:0] shifted;
  logic             cur_bit;
  logic [BIT_W-1:0] bit_inc;

  // bit under the pointer, zero once past the end of the stored message
  assign shifted = cur.message_store << cur_bit_index;
  assign cur_bit = shifted[MSG_W-1];
  assign bit_inc = cur_bit_index + BIT_W'(1);

  // phase sequencing
  always_comb begin
    logic acc;
    acc           = 1'b0;
    nxt           = cur;
    nxt_bit_index = cur_bit_index;
    if (in_word.opcode == OP_SEND) begin
      if (cur.phase == PH_IDLE) begin
        nxt.message_store = in_word.message;
        nxt.en            = 1'b0;
        nxt.clk           = 1'b1;
        nxt.dat           = 1'b1;
        nxt_bit_index     = '0;
        nxt.second_pass   = 1'b0;
        nxt.wait_count    = cfg.gap_ticks;
        nxt.phase         = PH_ENA_R1;
        acc               = 1'b1;
      end
    end else if (cur.phase == PH_POST) begin
      nxt.phase = PH_IDLE;
    end else if (cur.phase != PH_IDLE) begin
      if (cur.wait_count <= TICK_W'(1)) begin
        // segment over: move on
        case (cur.phase)
          PH_ENA_R1: begin
            nxt.en         = 1'b1;
            nxt.wait_count = cfg.gap_ticks;
            nxt.phase      = PH_ENA_F1;
          end
          PH_ENA_F1: begin
            nxt.en         = 1'b0;
            nxt.wait_count = cfg.gap_ticks;
            nxt.phase      = PH_ENA_R2;
          end
          PH_ENA_R2, PH_ENA_R3: begin
            nxt.en         = 1'b1;
            nxt.wait_count = cfg.lead_ticks;
            nxt.phase      = PH_CLK_F;
          end
          PH_CLK_F: begin
            nxt.dat        = ~cur_bit;
            nxt.clk        = 1'b0;
            nxt.wait_count = cfg.clock_low_ticks;
            nxt.phase      = PH_CLK_R;
          end
          PH_CLK_R: begin
            nxt.clk       = 1'b1;
            nxt_bit_index = bit_inc;
            if (bit_inc >= BIT_W'(MSG_BITS)) begin
              if (!cur.second_pass) begin
                nxt.wait_count  = cfg.clock_low_ticks;
                nxt.phase       = PH_ENA_F2;
                nxt_bit_index   = '0;
                nxt.second_pass = 1'b1;
              end else begin
                nxt.wait_count = cfg.lead_ticks;
                nxt.phase      = PH_ENA_F3;
              end
            end else begin
              nxt.wait_count = cfg.clock_high_ticks;
              nxt.phase      = PH_CLK_F;
            end
          end
          PH_ENA_F2: begin
            nxt.en         = 1'b0;
            nxt.wait_count = cfg.gap_ticks;
            nxt.phase      = PH_ENA_R3;
          end
          PH_ENA_F3: begin
            nxt.en         = 1'b0;
            nxt.dat        = 1'b1;
            nxt.wait_count = '0;
            nxt.phase      = PH_POST;
          end
          default: begin
            nxt.phase = PH_IDLE;
          end
        endcase
      end else begin
        nxt.wait_count = cur.wait_count - TICK_W'(1);
      end
    end
    out_word.accepted   = acc;
    out_word.busy_res   = (nxt.phase != PH_IDLE);
    out_word.enable_pin = nxt.en;
    out_word.clock_pin  = nxt.clk;
    out_word.data_pin   = nxt.dat;
  end

endmodule

[rtl/core/three_wire_display_frame_sender.sv]
// top level of the three-wire display frame sender: state, config and result registers
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid / in_ready     | in_word  (opcode, message)
//  out     | output    | out_valid / out_ready   | out_word (accepted, busy_res,
//          |           |                         |   enable_pin, clock_pin, data_pin)
//  cfg     | input     | cfg_we (no wait)        | cfg_index, cfg_data
//
// the next state and result of each input word are formed in one pass of tdfs_step
// and registered together, so one word is taken each clock unless out_ready stalls.
// in_ready is high while the result register is empty or being drained this cycle.
// a stall on out_ready holds the result register and blocks further input words.
// synchronous reset returns the frame to idle, lines to enable low, clock and data
// high, and the registers to their default tick counts.
module three_wire_display_frame_sender #(
  parameter int unsigned MSG_BITS = 56
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdfs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tdfs_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import tdfs_pkg::*;

  localparam int unsigned BIT_W = $clog2(MSG_BITS + 1);

  cfg_t             cfg;
  state_t           state;
  state_t           state_next;
  logic [BIT_W-1:0] bit_index;
  logic [BIT_W-1:0] bit_index_next;
  out_word_t        result_next;
  logic             in_take;

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_ticks        <= GAP_TICKS_RST;
      cfg.lead_ticks       <= LEAD_TICKS_RST;
      cfg.clock_high_ticks <= CLOCK_HIGH_TICKS_RST;
      cfg.clock_low_ticks  <= CLOCK_LOW_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAP_TICKS:        cfg.gap_ticks        <= cfg_data;
        CFG_LEAD_TICKS:       cfg.lead_ticks       <= cfg_data;
        CFG_CLOCK_HIGH_TICKS: cfg.clock_high_ticks <= cfg_data;
        CFG_CLOCK_LOW_TICKS:  cfg.clock_low_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state and result for the word on the input
  tdfs_step #(
    .MSG_BITS (MSG_BITS),
    .BIT_W    (BIT_W)
  ) u_step (
    .cur           (state),
    .cur_bit_index (bit_index),
    .cfg           (cfg),
    .in_word       (in_word),
    .nxt           (state_next),
    .nxt_bit_index (bit_index_next),
    .out_word      (result_next)
  );

  // frame state; the message store is not reset and is only loaded on a taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.wait_count  <= '0;
      state.second_pass <= 1'b0;
      state.en          <= 1'b0;
      state.clk         <= 1'b1;
      state.dat         <= 1'b1;
      bit_index         <= '0;
    end else if (in_take) begin
      state.phase         <= state_next.phase;
      state.wait_count    <= state_next.wait_count;
      state.second_pass   <= state_next.second_pass;
      state.message_store <= state_next.message_store;
      state.en            <= state_next.en;
      state.clk           <= state_next.clk;
      state.dat           <= state_next.dat;
      bit_index           <= bit_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_word <= result_next;
    end
  end

  // a taken send always leaves the frame running
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.accepted || out_word.busy_res))
    else $error("accepted send without busy");

  // idle lines: enable low, clock and data high
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_IDLE) |-> (!state.en && state.clk && state.dat))
    else $error("lines not at idle levels while idle");

  // a send taken while idle starts the first enable segment
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_word.opcode == OP_SEND && state.phase == PH_IDLE)
      |=> (state.phase == PH_ENA_R1 && out_word.accepted))
    else $error("send from idle did not start a frame");

  // bit counter never exceeds MSG_BITS
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_W'(MSG_BITS))
    else $error("bit counter out of range");

endmodule
